>>> hdl/hrhp_pkg.sv
// shared types, character codes and lookup functions of the request header parser
// no dependencies: compiled before every other file of the block
package hrhp_pkg;

  localparam int PATH_BYTES_DEF  = 256;
  localparam int QUERY_BYTES_DEF = 256;
  localparam int HOST_BYTES_DEF  = 64;

  localparam logic [1:0] REQ_FEED  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic [1:0] STORE_PATH  = 2'd0;
  localparam logic [1:0] STORE_QUERY = 2'd1;
  localparam logic [1:0] STORE_HOST  = 2'd2;

  localparam logic [1:0] STAT_MORE = 2'd0;
  localparam logic [1:0] STAT_DONE = 2'd1;
  localparam logic [1:0] STAT_BAD  = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_QMARK = 8'h3f;
  localparam logic [7:0] CH_LOW_H = 8'h68;

  // method names, first letter in the low byte
  localparam logic [55:0] METH_NAME [8] = '{
    56'h00000000544547, 56'h00000054534f50, 56'h00000000545550, 56'h00000044414548,
    56'h00004543415254, 56'h004554454c4544, 56'h534e4f4954504f, 56'h5443454e4e4f43
  };
  localparam logic [3:0] METH_LEN [8] = '{
    4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd7
  };

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic wr;
    logic post;
    logic scan_rd;
    logic scan_chk;
    logic load;
  } hrhp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic exec_wr;
    logic exec_post;
    logic wr_last;
    logic wr_post;
    logic post_scan;
    logic scan_end;
  } hrhp_sts_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] v;
    if (b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b <= 8'h46) begin
      v = b - 8'h37;
    end else begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

  function automatic logic [7:0] host_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = 8'h68;
      2'd1: c = 8'h6f;
      2'd2: c = 8'h73;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] http_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = 8'h68;
      2'd3: c = 8'h70;
      default: c = 8'h74;
    endcase
    return c;
  endfunction

  // {hit, code}
  function automatic logic [3:0] method_lookup(input logic [55:0] chars, input logic [3:0] n);
    logic [3:0] r;
    r = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (chars == METH_NAME[k] && n == METH_LEN[k]) begin
        r = {1'b1, 3'(k)};
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/hrhp_ctrl.sv
// sequencer of the request header parser: handshakes and per-item step order
// depends on hrhp_pkg for the command and status structs
module hrhp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output hrhp_pkg::hrhp_cmd_t cmd,
  input  hrhp_pkg::hrhp_sts_t sts
);
  import hrhp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WR, S_POST, S_SCAN_RD, S_SCAN_CHK, S_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == S_IDLE || (state_r == S_LOAD && out_free));
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.latch    = in_valid && !in_stall;
    cmd.exec     = state_r == S_EXEC;
    cmd.wr       = state_r == S_WR;
    cmd.post     = state_r == S_POST;
    cmd.scan_rd  = state_r == S_SCAN_RD;
    cmd.scan_chk = state_r == S_SCAN_CHK;
    cmd.load     = state_r == S_LOAD && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = cmd.load ? 1'b1 : (out_valid_r && out_stall);
    unique case (state_r)
      S_IDLE: begin
        if (cmd.latch) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.exec_wr) state_nxt = S_WR;
        else if (sts.exec_post) state_nxt = S_POST;
        else state_nxt = S_LOAD;
      end
      S_WR: begin
        if (sts.wr_last) state_nxt = sts.wr_post ? S_POST : S_LOAD;
      end
      S_POST: begin
        state_nxt = sts.post_scan ? S_SCAN_RD : S_LOAD;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_nxt = sts.scan_end ? S_LOAD : S_SCAN_RD;
      end
      S_LOAD: begin
        if (out_free) state_nxt = cmd.latch ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/hrhp_dp.sv
// datapath of the request header parser: parse registers, stores, back-up scan
// depends on hrhp_pkg; driven by hrhp_ctrl through command and status structs
module hrhp_dp #(
  parameter int PATH_BYTES  = hrhp_pkg::PATH_BYTES_DEF,
  parameter int QUERY_BYTES = hrhp_pkg::QUERY_BYTES_DEF,
  parameter int HOST_BYTES  = hrhp_pkg::HOST_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hrhp_pkg::hrhp_cmd_t          cmd,
  output hrhp_pkg::hrhp_sts_t          sts,
  input  logic [1:0]                  in_req_type,
  input  logic [7:0]                  in_data_byte,
  input  logic [1:0]                  in_read_store,
  input  logic [7:0]                  in_read_index,
  output logic [1:0]                  res_status,
  output logic [2:0]                  res_method,
  output logic [7:0]                  res_major,
  output logic [7:0]                  res_minor,
  output logic [$clog2(PATH_BYTES):0]  res_path_len,
  output logic                        res_query_present,
  output logic [$clog2(QUERY_BYTES):0] res_query_len,
  output logic                        res_host_present,
  output logic [$clog2(HOST_BYTES):0]  res_host_len,
  output logic [7:0]                  res_read_data
);
  import hrhp_pkg::*;

  localparam int PAW = $clog2(PATH_BYTES);
  localparam int PLW = PAW + 1;
  localparam int QAW = $clog2(QUERY_BYTES);
  localparam int QLW = QAW + 1;
  localparam int HAW = $clog2(HOST_BYTES);
  localparam int HLW = HAW + 1;
  localparam logic [3:0] VS_BAD = 4'd10;

  typedef enum logic [4:0] {
    LS_START, LS_METHOD, LS_METHOD_SP, LS_URL, LS_URL_SP, LS_PROTO, LS_PROTO_LF,
    LS_LINE, LS_RNR, LS_NAME, LS_NAME_END, LS_NAME_END_R, LS_NAME_END_RN,
    LS_VALUE, LS_VALUE_R, LS_VALUE_RN, LS_DONE, LS_FAIL, LS_OVF
  } ls_t;
  typedef enum logic [1:0] {US_PATH, US_PCT, US_PCT_HEX, US_QUERY} us_t;
  typedef enum logic [1:0] {DS_NORMAL, DS_SLASH, DS_SDOT, DS_SDD} ds_t;
  typedef enum logic [1:0] {PK_NONE, PK_DOT, PK_END, PK_RAW} pk_t;

  // latched item
  logic [1:0] rt_r, store_r;
  logic [7:0] byte_r, idx_r;

  // parse state
  ls_t         ls_r, ls_nxt;
  us_t         us_r, us_nxt;
  ds_t         ds_r, ds_nxt;
  pk_t         pk_r, pk_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [PLW-1:0] pptr_r, pptr_nxt;
  logic [QLW-1:0] qptr_r, qptr_nxt;
  logic [HLW-1:0] hptr_r, hptr_nxt;
  logic [55:0] mch_r, mch_nxt;
  logic [3:0]  tok_r, tok_nxt;
  logic [3:0]  vs_r, vs_nxt;
  logic [7:0]  maj_r, maj_nxt, min_r, min_nxt;
  logic [2:0]  nm_r, nm_nxt;
  logic        dfq_r, dfq_nxt, dfh_r, dfh_nxt, dfc_r, dfc_nxt;
  logic [1:0]  qn_r, qn_nxt;

  // write queue and scan payload
  logic [7:0]  qb_r [3];
  logic [7:0]  qb_nxt [3];
  logic [1:0]  qsel_r, qsel_nxt;
  logic [7:0]  pch_r, pch_nxt;
  logic [PAW-1:0] scan_r, scan_nxt;

  // stores
  logic [7:0] path_mem  [PATH_BYTES];
  logic [7:0] query_mem [QUERY_BYTES];
  logic [7:0] host_mem  [HOST_BYTES];
  logic [7:0] prd_r, qrd_r, hrd_r;
  logic       pw_en, qw_en, hw_en;
  logic [PAW-1:0] pra;

  // byte classification
  logic [7:0] b, lb;
  logic       ws, dig;
  logic [3:0] d, mhit;

  // scratch
  logic       url_go, ver_go, end_go, ovf_now, scan_go, scan_fin, dend;
  logic [1:0] hput_n;
  logic [7:0] hb0, hb1, hb2, dch, dec_b, mbase;
  logic [PLW-1:0] dold, dq, dx;
  logic [11:0] mv;

  assign b     = byte_r;
  assign lb    = to_lower(byte_r);
  assign ws    = byte_r == CH_SP || byte_r == CH_TAB;
  assign dig   = byte_r >= 8'h30 && byte_r <= 8'h39;
  assign d     = byte_r[3:0];
  assign mhit  = method_lookup(mch_r, tok_r);
  assign dec_b = {hex_val(held_r), hex_val(byte_r)};
  assign mbase = (vs_r == 4'd6) ? maj_r : min_r;
  assign mv    = 12'(mbase) * 12'd10 + 12'(d);
  assign pra   = cmd.scan_rd ? scan_r : PAW'(idx_r);

  always_comb begin
    ls_nxt = ls_r; us_nxt = us_r; ds_nxt = ds_r; pk_nxt = pk_r;
    held_nxt = held_r; pptr_nxt = pptr_r; qptr_nxt = qptr_r; hptr_nxt = hptr_r;
    mch_nxt = mch_r; tok_nxt = tok_r; vs_nxt = vs_r; maj_nxt = maj_r; min_nxt = min_r;
    nm_nxt = nm_r; dfq_nxt = dfq_r; dfh_nxt = dfh_r; dfc_nxt = dfc_r; qn_nxt = qn_r;
    for (int i = 0; i < 3; i++) qb_nxt[i] = qb_r[i];
    qsel_nxt = qsel_r; pch_nxt = pch_r; scan_nxt = scan_r;
    pw_en = 1'b0; qw_en = 1'b0; hw_en = 1'b0;
    url_go = 1'b0; ver_go = 1'b0; end_go = 1'b0; ovf_now = 1'b0;
    scan_go = 1'b0; scan_fin = 1'b0;
    hput_n = 2'd0; hb0 = b; hb1 = b; hb2 = b;
    dend = 1'b0; dch = '0; dold = '0; dq = '0; dx = '0;

    if (cmd.exec) begin
      qn_nxt = 2'd0;
      pk_nxt = PK_NONE;
      if (rt_r == REQ_START) begin
        ls_nxt = LS_START; us_nxt = US_PATH; ds_nxt = DS_NORMAL;
        held_nxt = '0; pptr_nxt = '0; qptr_nxt = '0; hptr_nxt = '0;
        mch_nxt = '0; tok_nxt = '0; vs_nxt = '0; maj_nxt = '0; min_nxt = '0;
        nm_nxt = '0; dfq_nxt = 1'b0; dfh_nxt = 1'b0; dfc_nxt = 1'b0;
      end else if (rt_r == REQ_FEED && ls_r < LS_DONE) begin
        unique case (ls_r)
          LS_START: begin
            mch_nxt = {48'd0, b};
            tok_nxt = 4'd1;
            ls_nxt  = LS_METHOD;
          end
          LS_METHOD: begin
            if (b == CH_SP) begin
              ls_nxt = mhit[3] ? LS_METHOD_SP : LS_FAIL;
            end else begin
              for (int i = 0; i < 7; i++) begin
                if (tok_r == 4'(i)) mch_nxt[i*8 +: 8] = b;
              end
              if (tok_r < 4'd8) tok_nxt = tok_r + 4'd1;
            end
          end
          LS_METHOD_SP: begin
            if (b != CH_SP) begin
              ls_nxt = LS_URL;
              url_go = 1'b1;
            end
          end
          LS_URL: begin
            if (b == CH_SP) begin
              ls_nxt = LS_URL_SP;
              end_go = us_r != US_QUERY;
            end else begin
              url_go = 1'b1;
            end
          end
          LS_URL_SP: begin
            if (b != CH_SP) begin
              ls_nxt = LS_PROTO;
              ver_go = 1'b1;
            end
          end
          LS_PROTO: begin
            if (b == CH_CR) begin
              ls_nxt = ((vs_r == 4'd8 || vs_r == 4'd9) && maj_r != 8'd0) ? LS_PROTO_LF
                                                                         : LS_FAIL;
            end else begin
              ver_go = 1'b1;
            end
          end
          LS_PROTO_LF: ls_nxt = (b == CH_LF) ? LS_LINE : LS_FAIL;
          LS_LINE: begin
            if (b == CH_CR) begin
              ls_nxt = LS_RNR;
            end else begin
              ls_nxt = LS_NAME;
              nm_nxt = (lb == CH_LOW_H) ? 3'd1 : 3'd7;
            end
          end
          LS_RNR: ls_nxt = (b == CH_LF) ? LS_DONE : LS_FAIL;
          LS_NAME: begin
            if (b == CH_COLON) begin
              if (nm_r == 3'd4) begin
                dfc_nxt  = 1'b1;
                hptr_nxt = '0;
              end else begin
                dfc_nxt = 1'b0;
              end
              ls_nxt = LS_NAME_END;
            end else begin
              nm_nxt = (nm_r < 3'd4 && lb == host_char(nm_r[1:0])) ? nm_r + 3'd1 : 3'd7;
            end
          end
          LS_NAME_END: begin
            if (b == CH_CR) begin
              ls_nxt = LS_NAME_END_R;
            end else if (!ws) begin
              ls_nxt = LS_VALUE;
              hput_n = 2'd1;
            end
          end
          LS_NAME_END_R, LS_VALUE_R: begin
            if (b == CH_LF) begin
              ls_nxt = (ls_r == LS_VALUE_R) ? LS_VALUE_RN : LS_NAME_END_RN;
            end else begin
              ls_nxt = LS_VALUE;
              hput_n = 2'd2;
              hb0    = CH_CR;
            end
          end
          LS_NAME_END_RN, LS_VALUE_RN: begin
            if (ws) begin
              if (ls_r == LS_VALUE_RN) begin
                ls_nxt = LS_VALUE;
                hput_n = 2'd3;
                hb0    = CH_CR;
                hb1    = CH_LF;
              end else begin
                ls_nxt = LS_NAME_END;
              end
            end else begin
              dfh_nxt = dfh_r | dfc_r;
              dfc_nxt = 1'b0;
              if (b == CH_CR) begin
                ls_nxt = LS_RNR;
              end else begin
                ls_nxt = LS_NAME;
                nm_nxt = (lb == CH_LOW_H) ? 3'd1 : 3'd7;
              end
            end
          end
          LS_VALUE: begin
            if (b == CH_CR) ls_nxt = LS_VALUE_R;
            else hput_n = 2'd1;
          end
          default: ;
        endcase
      end

      // target bytes
      if (url_go) begin
        if (us_r == US_QUERY) begin
          qn_nxt = 2'd1; qsel_nxt = STORE_QUERY; qb_nxt[0] = b;
        end else if (b == CH_QMARK) begin
          end_go = 1'b1; dfq_nxt = 1'b1; us_nxt = US_QUERY;
        end else if (us_r == US_PATH) begin
          if (b == CH_PCT) begin
            us_nxt = US_PCT;
          end else begin
            qn_nxt = 2'd1; qsel_nxt = STORE_PATH; qb_nxt[0] = b;
            pch_nxt = b; pk_nxt = PK_DOT;
          end
        end else if (us_r == US_PCT) begin
          if (is_hex(b)) begin
            held_nxt = b; us_nxt = US_PCT_HEX;
          end else begin
            us_nxt = US_PATH; qn_nxt = 2'd2; qsel_nxt = STORE_PATH;
            qb_nxt[0] = CH_PCT; qb_nxt[1] = b; pk_nxt = PK_RAW;
          end
        end else begin
          us_nxt = US_PATH; qsel_nxt = STORE_PATH;
          if (is_hex(b)) begin
            qn_nxt = 2'd1; qb_nxt[0] = dec_b; pch_nxt = dec_b; pk_nxt = PK_DOT;
          end else begin
            qn_nxt = 2'd3; qb_nxt[0] = CH_PCT; qb_nxt[1] = held_r; qb_nxt[2] = b;
            pk_nxt = PK_RAW;
          end
        end
      end

      // path end: flush a pending escape, else settle a trailing dot segment
      if (end_go) begin
        qsel_nxt = STORE_PATH;
        if (us_r == US_PCT) begin
          qn_nxt = 2'd1; qb_nxt[0] = CH_PCT; pk_nxt = PK_RAW;
        end else if (us_r == US_PCT_HEX) begin
          qn_nxt = 2'd2; qb_nxt[0] = CH_PCT; qb_nxt[1] = held_r; pk_nxt = PK_RAW;
        end else begin
          pk_nxt = PK_END;
        end
      end

      // version digits
      if (ver_go) begin
        if (vs_r < 4'd4) begin
          vs_nxt = (lb == http_char(vs_r[1:0])) ? vs_r + 4'd1 : VS_BAD;
        end else if (vs_r == 4'd4) begin
          vs_nxt = (b == CH_SLASH) ? 4'd5 : VS_BAD;
        end else if (vs_r == 4'd5) begin
          if (dig) begin
            maj_nxt = 8'(d); vs_nxt = 4'd6;
          end else begin
            vs_nxt = VS_BAD;
          end
        end else if (vs_r == 4'd6) begin
          if (dig) maj_nxt = (mv > 12'd255) ? 8'd255 : mv[7:0];
          else vs_nxt = (b == CH_DOT) ? 4'd7 : VS_BAD;
        end else if (vs_r == 4'd7) begin
          if (dig) begin
            min_nxt = 8'(d); vs_nxt = 4'd8;
          end else begin
            vs_nxt = VS_BAD;
          end
        end else if (vs_r == 4'd8) begin
          if (dig) min_nxt = (mv > 12'd255) ? 8'd255 : mv[7:0];
          else vs_nxt = 4'd9;
        end
      end

      if (hput_n != 2'd0 && dfc_r) begin
        qn_nxt = hput_n; qsel_nxt = STORE_HOST;
        qb_nxt[0] = hb0; qb_nxt[1] = hb1; qb_nxt[2] = hb2;
      end
    end

    // one store byte per cycle
    if (cmd.wr) begin
      if (qsel_r == STORE_PATH) ovf_now = pptr_r >= PLW'(PATH_BYTES);
      else if (qsel_r == STORE_QUERY) ovf_now = qptr_r >= QLW'(QUERY_BYTES);
      else ovf_now = hptr_r >= HLW'(HOST_BYTES);
      if (ovf_now) begin
        ls_nxt = LS_OVF; qn_nxt = 2'd0; pk_nxt = PK_NONE;
      end else begin
        if (qsel_r == STORE_PATH) begin
          pw_en = 1'b1; pptr_nxt = pptr_r + PLW'(1);
        end else if (qsel_r == STORE_QUERY) begin
          qw_en = 1'b1; qptr_nxt = qptr_r + QLW'(1);
        end else begin
          hw_en = 1'b1; hptr_nxt = hptr_r + HLW'(1);
        end
        qb_nxt[0] = qb_r[1];
        qb_nxt[1] = qb_r[2];
        qn_nxt    = qn_r - 2'd1;
      end
    end

    // dot segment tracking after a path byte or at path end
    if (cmd.post) begin
      pk_nxt = PK_NONE;
      if (pk_r == PK_RAW) begin
        ds_nxt = DS_NORMAL;
      end else begin
        dend = pk_r == PK_END;
        dch  = dend ? 8'd0 : pch_r;
        dold = dend ? pptr_r : pptr_r - PLW'(1);
        if (!dend && dold == '0 && dch == CH_DOT) begin
          ds_nxt = DS_SDOT;
        end else begin
          ds_nxt = DS_NORMAL;
          unique case (ds_r)
            DS_NORMAL: begin
              if (!dend && dch == CH_SLASH) ds_nxt = DS_SLASH;
            end
            DS_SLASH: begin
              if (!dend && dch == CH_DOT) ds_nxt = DS_SDOT;
              else if (!dend && dch == CH_SLASH) pptr_nxt = pptr_r - PLW'(1);
            end
            DS_SDOT: begin
              if (dend) pptr_nxt = (pptr_r >= PLW'(1)) ? pptr_r - PLW'(1) : '0;
              else if (dch == CH_DOT) ds_nxt = DS_SDD;
              else if (dch == CH_SLASH) pptr_nxt = (pptr_r >= PLW'(2)) ? pptr_r - PLW'(2) : '0;
            end
            default: begin
              if (dend || dch == CH_SLASH) begin
                dq = pptr_r + PLW'(dend);
                dx = (dq >= PLW'(3)) ? dq - PLW'(3) : '0;
                if (dx > PLW'(1)) begin
                  scan_go  = 1'b1;
                  scan_nxt = PAW'(dx - PLW'(2));
                end else begin
                  pptr_nxt = dx;
                end
              end
            end
          endcase
        end
      end
    end

    // back-up scan toward the previous slash
    if (cmd.scan_chk) begin
      if (prd_r == CH_SLASH) begin
        pptr_nxt = PLW'(scan_r) + PLW'(1);
        scan_fin = 1'b1;
      end else if (scan_r == '0) begin
        pptr_nxt = '0;
        scan_fin = 1'b1;
      end else begin
        scan_nxt = scan_r - PAW'(1);
      end
    end
  end

  always_comb begin
    sts           = '0;
    sts.exec_wr   = cmd.exec && qn_nxt != 2'd0;
    sts.exec_post = cmd.exec && pk_nxt != PK_NONE;
    sts.wr_last   = ovf_now || qn_r == 2'd1;
    sts.wr_post   = !ovf_now && pk_r != PK_NONE;
    sts.post_scan = scan_go;
    sts.scan_end  = scan_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r <= LS_START; us_r <= US_PATH; ds_r <= DS_NORMAL; pk_r <= PK_NONE;
      held_r <= '0; pptr_r <= '0; qptr_r <= '0; hptr_r <= '0;
      mch_r <= '0; tok_r <= '0; vs_r <= '0; maj_r <= '0; min_r <= '0;
      nm_r <= '0; dfq_r <= 1'b0; dfh_r <= 1'b0; dfc_r <= 1'b0; qn_r <= '0;
    end else begin
      ls_r <= ls_nxt; us_r <= us_nxt; ds_r <= ds_nxt; pk_r <= pk_nxt;
      held_r <= held_nxt; pptr_r <= pptr_nxt; qptr_r <= qptr_nxt; hptr_r <= hptr_nxt;
      mch_r <= mch_nxt; tok_r <= tok_nxt; vs_r <= vs_nxt; maj_r <= maj_nxt;
      min_r <= min_nxt; nm_r <= nm_nxt; dfq_r <= dfq_nxt; dfh_r <= dfh_nxt;
      dfc_r <= dfc_nxt; qn_r <= qn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) qb_r[i] <= qb_nxt[i];
    qsel_r <= qsel_nxt;
    pch_r  <= pch_nxt;
    scan_r <= scan_nxt;
    if (cmd.latch) begin
      rt_r    <= in_req_type;
      byte_r  <= in_data_byte;
      store_r <= in_read_store;
      idx_r   <= in_read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) path_mem[PAW'(pptr_r)] <= qb_r[0];
    prd_r <= path_mem[pra];
  end

  always_ff @(posedge clk) begin
    if (qw_en) query_mem[QAW'(qptr_r)] <= qb_r[0];
    qrd_r <= query_mem[QAW'(idx_r)];
  end

  always_ff @(posedge clk) begin
    if (hw_en) host_mem[HAW'(hptr_r)] <= qb_r[0];
    hrd_r <= host_mem[HAW'(idx_r)];
  end

  always_comb begin
    res_read_data = 8'd0;
    if (rt_r == REQ_READ) begin
      if (store_r == STORE_PATH && 32'(idx_r) < 32'(pptr_r)) res_read_data = prd_r;
      else if (store_r == STORE_QUERY && 32'(idx_r) < 32'(qptr_r)) res_read_data = qrd_r;
      else if (store_r == STORE_HOST && 32'(idx_r) < 32'(hptr_r)) res_read_data = hrd_r;
    end
  end

  always_comb begin
    if (ls_r == LS_DONE) res_status = STAT_DONE;
    else if (ls_r == LS_FAIL) res_status = STAT_BAD;
    else if (ls_r == LS_OVF) res_status = STAT_OVF;
    else res_status = STAT_MORE;
  end

  assign res_method        = (ls_r > LS_METHOD && mhit[3]) ? mhit[2:0] : 3'd0;
  assign res_major         = maj_r;
  assign res_minor         = min_r;
  assign res_path_len      = pptr_r;
  assign res_query_present = dfq_r;
  assign res_query_len     = qptr_r;
  assign res_host_present  = dfh_r;
  assign res_host_len      = hptr_r;

endmodule

>>> hdl/http_request_header_parser.sv
// top level of the http request line and header parser
// depends on hrhp_pkg, hrhp_ctrl and hrhp_dp
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------------
//  in      | in_valid / in_stall | req_type, data_byte, read_store, read_index
//  out     | out_valid/out_stall | status, method, version, lengths, flags, read_data
//
// a plain feed byte or a read passes the exec and load states; each store byte
// written adds a write state, a path byte or path end that touches dot tracking adds
// a post state; a '..' back-up reads then compares each path store entry toward the slash
// synchronous active-low reset clears the parse state; stores need no clearing
// an out_stall holds the finished item in the output register while the next item
// runs; the input stalls while an item is in work, and beyond those cycles a ready
// item waits only while the output register is still full
module http_request_header_parser #(
  parameter int PATH_BYTES  = hrhp_pkg::PATH_BYTES_DEF,
  parameter int QUERY_BYTES = hrhp_pkg::QUERY_BYTES_DEF,
  parameter int HOST_BYTES  = hrhp_pkg::HOST_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_req_type,
  input  logic [7:0]                  in_data_byte,
  input  logic [1:0]                  in_read_store,
  input  logic [7:0]                  in_read_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [2:0]                  out_method,
  output logic [7:0]                  out_version_major,
  output logic [7:0]                  out_version_minor,
  output logic [$clog2(PATH_BYTES):0]  out_path_length,
  output logic                        out_query_present,
  output logic [$clog2(QUERY_BYTES):0] out_query_length,
  output logic                        out_host_present,
  output logic [$clog2(HOST_BYTES):0]  out_host_length,
  output logic [7:0]                  out_read_data
);
  import hrhp_pkg::*;

  hrhp_cmd_t cmd;
  hrhp_sts_t sts;

  // datapath view of the result item
  logic [1:0]                  res_status;
  logic [2:0]                  res_method;
  logic [7:0]                  res_major, res_minor, res_read_data;
  logic [$clog2(PATH_BYTES):0]  res_path_len;
  logic [$clog2(QUERY_BYTES):0] res_query_len;
  logic [$clog2(HOST_BYTES):0]  res_host_len;
  logic                        res_query_present, res_host_present;

  // output register
  logic [1:0]                  status_r;
  logic [2:0]                  method_r;
  logic [7:0]                  major_r, minor_r, read_data_r;
  logic [$clog2(PATH_BYTES):0]  path_len_r;
  logic [$clog2(QUERY_BYTES):0] query_len_r;
  logic [$clog2(HOST_BYTES):0]  host_len_r;
  logic                        query_present_r, host_present_r;

  hrhp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  hrhp_dp #(
    .PATH_BYTES  (PATH_BYTES),
    .QUERY_BYTES (QUERY_BYTES),
    .HOST_BYTES  (HOST_BYTES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .in_read_store     (in_read_store),
    .in_read_index     (in_read_index),
    .res_status        (res_status),
    .res_method        (res_method),
    .res_major         (res_major),
    .res_minor         (res_minor),
    .res_path_len      (res_path_len),
    .res_query_present (res_query_present),
    .res_query_len     (res_query_len),
    .res_host_present  (res_host_present),
    .res_host_len      (res_host_len),
    .res_read_data     (res_read_data)
  );

  // capture the finished item once the register is free
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r        <= res_status;
      method_r        <= res_method;
      major_r         <= res_major;
      minor_r         <= res_minor;
      path_len_r      <= res_path_len;
      query_present_r <= res_query_present;
      query_len_r     <= res_query_len;
      host_present_r  <= res_host_present;
      host_len_r      <= res_host_len;
      read_data_r     <= res_read_data;
    end
  end

  assign out_status        = status_r;
  assign out_method        = method_r;
  assign out_version_major = major_r;
  assign out_version_minor = minor_r;
  assign out_path_length   = path_len_r;
  assign out_query_present = query_present_r;
  assign out_query_length  = query_len_r;
  assign out_host_present  = host_present_r;
  assign out_host_length   = host_len_r;
  assign out_read_data     = read_data_r;

endmodule
